FILE: rtl/core/rqpf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rqpf_pkg: ready queue priority FIFO shared definitions
// Entry, request and result types plus operation and status codes.
// ---------------------------------------------------------------------------
package rqpf_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic   op;
		entry_t entry;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] taken_id;
		logic [7:0]  taken_prio;
		logic [4:0]  entry_count;
		logic        is_empty;
	} result_t;

endpackage : rqpf_pkg
`default_nettype wire

FILE: rtl/core/rqpf_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rqpf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rqpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : rqpf_ram
`default_nettype wire

FILE: rtl/core/rqpf_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rqpf_ctrl: queue sequencer
// Holds the entry RAM and count, scans for the entry to take with one
// shared compare, then closes the gap one entry per cycle.
// ---------------------------------------------------------------------------
module rqpf_ctrl #(
	parameter int QUEUE_DEPTH = rqpf_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rqpf_pkg::req_t    req,
	input  wire logic              fifo_mode,
	output logic                   idle,
	output logic                   done,
	output rqpf_pkg::result_t      res
);
	import rqpf_pkg::*;

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_MOVE = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  limit_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [ADDR_W-1:0] best_idx_q;
	entry_t            best_q;
	result_t           res_q;

	logic              issue;
	logic              last;
	logic              take_new;
	logic [ADDR_W-1:0] sel_idx;
	entry_t            sel_entry;
	logic [CNT_W-1:0]  sel_next;
	logic [CNT_W-1:0]  count_dec;
	logic              full;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] rd_raw;
	entry_t            rd_data;

	rqpf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_ptr_q[ADDR_W-1:0]),
		.rd_data (rd_raw)
	);

	assign rd_data   = entry_t'(rd_raw);
	assign full      = (count_q == FULL_CNT);
	assign count_dec = count_q - 1'b1;

	// one read per cycle in scan and move, its index registered alongside the read data
	assign issue = ((state_q == S_SCAN) || (state_q == S_MOVE)) && (rd_ptr_q < limit_q);
	assign last  = vld_s1 && (CNT_W'(idx_s1) == (limit_q - 1'b1));

	// strict less keeps the earliest of equal priorities
	assign take_new  = (state_q == S_SCAN) && vld_s1 &&
		((idx_s1 == '0) || (rd_data.prio < best_q.prio));
	assign sel_idx   = take_new ? idx_s1  : best_idx_q;
	assign sel_entry = take_new ? rd_data : best_q;
	assign sel_next  = CNT_W'(sel_idx) + 1'b1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = req.entry;
		if ((state_q == S_IDLE) && start && (req.op == OP_ENQ) && !full) begin
			wr_en = 1'b1;
		end else if ((state_q == S_MOVE) && vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - 1'b1;
			wr_data = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				idx_s1   <= rd_ptr_q[ADDR_W-1:0];
			end
			if (take_new) begin
				best_idx_q <= idx_s1;
				best_q     <= rd_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q.taken_id   <= '0;
						res_q.taken_prio <= '0;
						if (req.op == OP_ENQ) begin
							if (full) begin
								res_q.status      <= ST_FULL;
								res_q.entry_count <= 5'(count_q);
								res_q.is_empty    <= (count_q == '0);
							end else begin
								count_q           <= count_q + 1'b1;
								res_q.status      <= ST_OK;
								res_q.entry_count <= 5'(count_q + 1'b1);
								res_q.is_empty    <= 1'b0;
							end
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							res_q.status      <= ST_EMPTY;
							res_q.entry_count <= '0;
							res_q.is_empty    <= 1'b1;
							state_q           <= S_DONE;
						end else begin
							rd_ptr_q <= '0;
							limit_q  <= fifo_mode ? CNT_W'(1) : count_q;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (last) begin
						res_q.status      <= ST_OK;
						res_q.taken_id    <= sel_entry.id;
						res_q.taken_prio  <= sel_entry.prio;
						res_q.entry_count <= 5'(count_dec);
						res_q.is_empty    <= (count_dec == '0);
						if (sel_next < count_q) begin
							rd_ptr_q <= sel_next;
							limit_q  <= count_q;
							state_q  <= S_MOVE;
						end else begin
							count_q <= count_dec;
							state_q <= S_DONE;
						end
					end
				end
				S_MOVE: begin
					if (last) begin
						count_q <= count_dec;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);
	assign res  = res_q;

endmodule : rqpf_ctrl
`default_nettype wire

FILE: rtl/core/ready_queue_priority_fifo_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ready_queue_priority_fifo_unit: bounded ready queue of process entries
// Enqueue at the tail; dequeue the head (FIFO mode) or the lowest priority
// value, earliest on ties. One result item per input item.
// ---------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     operation, proc_id, prio_value
//  out      output     out_valid / out_ready   status, taken_id, taken_prio,
//                                              entry_count, is_empty
//  cfg      input      cfg_write_en            cfg_write_data (fifo_mode)
//
//  Enqueue: the entry is written at the tail on accept. Dequeue: the
//  sequencer scans the entries (only the head in FIFO mode, all of them
//  otherwise), then moves each entry behind the taken one up one place;
//  the move pass is skipped when no entry sits behind it. The single RAM
//  read port serves both scan and compaction, one entry per cycle.
//  One item at a time: in_ready is low from accept until the sequencer is idle.
//  The result waits in an output register; out_ready low stalls only the next
//  accept. Reset empties the queue and clears fifo_mode; no clearing pass.
// ---------------------------------------------------------------------------
module ready_queue_priority_fifo_unit #(
	parameter int QUEUE_DEPTH = rqpf_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [15:0] proc_id,
	input  wire logic [7:0]  prio_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      taken_id,
	output logic [7:0]       taken_prio,
	output logic [4:0]       entry_count,
	output logic             is_empty,
	input  wire logic        cfg_write_en,
	input  wire logic        cfg_write_data
);
	import rqpf_pkg::*;

	logic    fifo_mode_q;
	logic    out_valid_q;
	result_t out_res_q;
	logic    ctrl_idle;
	logic    ctrl_done;
	result_t ctrl_res;
	req_t    req;
	logic    accept;

	assign req.op         = operation;
	assign req.entry.id   = proc_id;
	assign req.entry.prio = prio_value;

	// the slot is free or draining at accept, so it is empty when the result lands
	assign in_ready = ctrl_idle && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	rqpf_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.req       (req),
		.fifo_mode (fifo_mode_q),
		.idle      (ctrl_idle),
		.done      (ctrl_done),
		.res       (ctrl_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				fifo_mode_q <= cfg_write_data;
			end
			if (ctrl_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_done) begin
			out_res_q <= ctrl_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_res_q.status;
	assign taken_id    = out_res_q.taken_id;
	assign taken_prio  = out_res_q.taken_prio;
	assign entry_count = out_res_q.entry_count;
	assign is_empty    = out_res_q.is_empty;

	a_done_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_done |-> !out_valid_q)
		else $error("result produced while output slot still full");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !ctrl_idle)
		else $error("sequencer idle right after accept");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_res_q.status == ST_EMPTY)) |-> out_res_q.is_empty)
		else $error("empty status without empty flag");

	a_nothing_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_res_q.status != ST_OK)) |->
			((out_res_q.taken_id == '0) && (out_res_q.taken_prio == '0)))
		else $error("entry reported on a failed item");

endmodule : ready_queue_priority_fifo_unit
`default_nettype wire
